// ----- design/timestamped_snapshot_interp_buffer_unit_assert.svh -----
// Assertion macros for the snapshot interpolation buffer.
`ifndef TIMESTAMPED_SNAPSHOT_INTERP_BUFFER_UNIT_ASSERT_SVH
`define TIMESTAMPED_SNAPSHOT_INTERP_BUFFER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TSIB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TSIB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/tsib_pkg.sv -----
// Shared constants and types for the snapshot interpolation buffer.
package tsib_pkg;
  localparam int TIME_W = 48;
  localparam int LAG_W = 16;
  localparam int MIX_W = 17;
  localparam int OUT_W = 32;
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] ST_SEED = 2'd0;
  localparam logic [1:0] ST_NEWEST = 2'd1;
  localparam logic [1:0] ST_BRACKET = 2'd2;
  localparam logic [1:0] ST_OLDEST = 2'd3;
  localparam logic [MIX_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [TIME_W-1:0] MIN_SPAN_US = 48'd10;
  localparam logic [0:0] REG_LAG = 1'b0;
  localparam logic [0:0] REG_ENABLE = 1'b1;
  typedef struct packed {
    logic start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;
endpackage

// ----- design/tsib_div.sv -----
// Iterative Q1.16 ratio unit, one quotient bit per cycle.
module tsib_div (
  input  logic clk,
  input  logic rst_n,
  input  tsib_pkg::div_req_t req,
  output logic done,
  output logic [tsib_pkg::MIX_W-1:0] quo
);
  logic [tsib_pkg::TIME_W:0] rem_r, rem_nxt, sh;
  logic [tsib_pkg::TIME_W-1:0] den_r;
  logic [15:0] q_r, q_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, one_r, one_nxt, done_r, done_nxt;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    one_nxt = one_r;
    done_nxt = 1'b0;
    sh = {rem_r[tsib_pkg::TIME_W-1:0], 1'b0};
    if (req.start) begin
      one_nxt = req.num >= req.den;
      rem_nxt = {1'b0, req.num};
      q_nxt = '0;
      cnt_nxt = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (one_r || cnt_r == 5'd16) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (sh >= {1'b0, den_r}) begin
          rem_nxt = sh - {1'b0, den_r};
          q_nxt = {q_r[14:0], 1'b1};
        end else begin
          rem_nxt = sh;
          q_nxt = {q_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    cnt_r <= cnt_nxt;
    one_r <= one_nxt;
    if (req.start) den_r <= req.den;
  end

  assign done = done_r;
  assign quo = one_r ? tsib_pkg::ONE_Q16 : {1'b0, q_r};
endmodule

// ----- design/timestamped_snapshot_interp_buffer_unit.sv -----
// Top level: timestamped snapshot ring with interpolated sampling.
// Push and clear complete on acceptance; a sample reads and checks one entry
// per walk step and, for a bracketed result, then waits on the ratio unit.
// Entries live in one synchronous memory read once per walk step.
// One item is in work at a time; a held result stalls the input until taken.
// Synchronous active-low reset clears state, pointer, count and configuration
// registers; clear resets pointer and count, the memory is not swept.
module timestamped_snapshot_interp_buffer_unit #(
  parameter int SLOTS = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // tdata: time_us[47:0], payload[PAYLOAD_BITS-1:0]
  input  logic [((PAYLOAD_BITS+48+7)/8)*8-1:0] in_tdata,
  // tuser: func[1:0]
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: older_payload[31:0], newer_payload[31:0], mix_fraction[16:0]
  output logic [87:0] out_tdata,
  // tuser: sample_status[1:0]
  output logic [1:0] out_tuser,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PW = PAYLOAD_BITS;
  localparam int EW = PW + tsib_pkg::TIME_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rd_r;

  logic [AW-1:0] wp_r, rd_addr_r, rd_addr_nxt;
  logic [CW-1:0] cnt_r, steps_r, steps_nxt;
  logic [2:0] st_r, st_nxt;
  logic [tsib_pkg::LAG_W-1:0] lag_r;
  logic en_r, first_r, first_nxt;
  logic [tsib_pkg::TIME_W-1:0] qt_r, qt_nxt, ct_r, ct_nxt;
  logic [PW-1:0] cp_r, cp_nxt;
  logic [1:0] func_in;
  logic [tsib_pkg::TIME_W-1:0] time_in, lag_us, rd_t;
  logic [PW-1:0] pay_in, rd_p;
  logic [PW-1:0] o_old_r, o_old_nxt, o_new_r, o_new_nxt;
  logic [tsib_pkg::MIX_W-1:0] o_mix_r, o_mix_nxt, div_q;
  logic [1:0] o_st_r, o_st_nxt;
  logic ov_r, ov_nxt, in_acc, push_we, div_done;
  tsib_pkg::div_req_t dreq;

  assign func_in = in_tuser;
  assign time_in = in_tdata[tsib_pkg::TIME_W-1:0];
  assign pay_in = in_tdata[EW-1:tsib_pkg::TIME_W];
  assign rd_t = rd_r[tsib_pkg::TIME_W-1:0];
  assign rd_p = rd_r[EW-1:tsib_pkg::TIME_W];
  assign lag_us = tsib_pkg::TIME_W'(lag_r) * 48'd1000;
  assign in_tready = (st_r == S_IDLE) && !ov_r;
  assign in_acc = in_tvalid && in_tready;
  assign push_we = in_acc && func_in == tsib_pkg::FUNC_PUSH;

  always_ff @(posedge clk) begin
    if (push_we) mem[wp_r] <= {pay_in, time_in};
    rd_r <= mem[rd_addr_r];
  end

  always_comb begin
    st_nxt = st_r;
    rd_addr_nxt = rd_addr_r;
    steps_nxt = steps_r;
    first_nxt = first_r;
    qt_nxt = qt_r;
    ct_nxt = ct_r;
    cp_nxt = cp_r;
    o_old_nxt = o_old_r;
    o_new_nxt = o_new_r;
    o_mix_nxt = o_mix_r;
    o_st_nxt = o_st_r;
    ov_nxt = ov_r && !out_tready;
    dreq = '0;
    case (st_r)
      S_IDLE: begin
        if (in_acc && func_in == tsib_pkg::FUNC_SAMPLE) begin
          if (!en_r || cnt_r < CW'(2)) begin
            o_old_nxt = pay_in;
            o_new_nxt = pay_in;
            o_mix_nxt = tsib_pkg::ONE_Q16;
            o_st_nxt = tsib_pkg::ST_SEED;
            ov_nxt = 1'b1;
          end else begin
            qt_nxt = time_in > lag_us ? time_in - lag_us : '0;
            rd_addr_nxt = (wp_r == '0) ? LAST_IDX : wp_r - AW'(1);
            steps_nxt = '0;
            first_nxt = 1'b1;
            st_nxt = S_READ;
          end
        end
      end
      S_READ: st_nxt = S_CHECK;
      S_CHECK: begin
        if (first_r) begin
          if (qt_r >= rd_t) begin
            o_old_nxt = rd_p;
            o_new_nxt = rd_p;
            o_mix_nxt = tsib_pkg::ONE_Q16;
            o_st_nxt = tsib_pkg::ST_NEWEST;
            ov_nxt = 1'b1;
            st_nxt = S_IDLE;
          end
        end else if (rd_t <= qt_r) begin
          o_old_nxt = rd_p;
          o_new_nxt = cp_r;
          o_st_nxt = tsib_pkg::ST_BRACKET;
          if (ct_r - rd_t > tsib_pkg::MIN_SPAN_US) begin
            dreq.start = 1'b1;
            dreq.num = qt_r - rd_t;
            dreq.den = ct_r - rd_t;
            st_nxt = S_DIV;
          end else begin
            o_mix_nxt = tsib_pkg::ONE_Q16;
            ov_nxt = 1'b1;
            st_nxt = S_IDLE;
          end
        end
        if (st_nxt == S_CHECK) begin
          ct_nxt = rd_t;
          cp_nxt = rd_p;
          first_nxt = 1'b0;
          if (steps_r + CW'(1) >= cnt_r) begin
            o_old_nxt = rd_p;
            o_new_nxt = rd_p;
            o_mix_nxt = '0;
            o_st_nxt = tsib_pkg::ST_OLDEST;
            ov_nxt = 1'b1;
            st_nxt = S_IDLE;
          end else begin
            steps_nxt = steps_r + CW'(1);
            rd_addr_nxt = (rd_addr_r == '0) ? LAST_IDX : rd_addr_r - AW'(1);
            st_nxt = S_READ;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          o_mix_nxt = div_q;
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  tsib_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (div_done),
    .quo  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      wp_r <= '0;
      cnt_r <= '0;
      lag_r <= '0;
      en_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (push_we) begin
        wp_r <= (wp_r == LAST_IDX) ? '0 : wp_r + AW'(1);
        if (cnt_r != FULL_CNT) cnt_r <= cnt_r + CW'(1);
      end else if (in_acc && func_in == tsib_pkg::FUNC_CLEAR) begin
        wp_r <= '0;
        cnt_r <= '0;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == tsib_pkg::REG_LAG) lag_r <= cfg_pwdata[15:0];
        else if (cfg_paddr[2] == tsib_pkg::REG_ENABLE) en_r <= cfg_pwdata[0];
      end
    end
    rd_addr_r <= rd_addr_nxt;
    steps_r <= steps_nxt;
    first_r <= first_nxt;
    qt_r <= qt_nxt;
    ct_r <= ct_nxt;
    cp_r <= cp_nxt;
    o_old_r <= o_old_nxt;
    o_new_r <= o_new_nxt;
    o_mix_r <= o_mix_nxt;
    o_st_r <= o_st_nxt;
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == tsib_pkg::REG_LAG) ? {16'd0, lag_r} :
                      {31'd0, en_r};
  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, o_mix_r, tsib_pkg::OUT_W'(o_new_r), tsib_pkg::OUT_W'(o_old_r)};
  assign out_tuser = o_st_r;

  `include "timestamped_snapshot_interp_buffer_unit_assert.svh"
  `TSIB_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= FULL_CNT)
  `TSIB_ASSERT_IMPL(a_busy_noaccept, clk, rst_n, st_r != S_IDLE, !in_tready)
  `TSIB_ASSERT_NEXT(a_newest_mix, clk, rst_n,
    ov_nxt && !ov_r && o_st_nxt == tsib_pkg::ST_NEWEST, o_mix_r == tsib_pkg::ONE_Q16)
  `TSIB_ASSERT_IMPL(a_oldest_mix, clk, rst_n,
    ov_r && o_st_r == tsib_pkg::ST_OLDEST, o_mix_r == '0)
endmodule
